// ===== design/mersenne_twister_zero_skip_top_defines.svh =====
// Assertion macros for the zero-skip twister generator.
`ifndef MERSENNE_TWISTER_ZERO_SKIP_TOP_DEFINES_SVH
`define MERSENNE_TWISTER_ZERO_SKIP_TOP_DEFINES_SVH

// Same-cycle implication, inactive during reset.
`define MTZS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive during reset.
`define MTZS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mtzs_pkg.sv =====
// Shared types, constants and word functions of the zero-skip twister generator.
`timescale 1ns / 1ps
package mtzs_pkg;

  localparam int N = 624;
  localparam int M = 397;
  localparam int IDX_W = 10;
  localparam int ZERO_W = 11;

  typedef logic [31:0] word_t;

  localparam word_t MASK_B     = 32'h9d2c5680;
  localparam word_t MASK_C     = 32'hefc60000;
  localparam word_t UPPER_BIT  = 32'h80000000;
  localparam word_t LOWER_BITS = 32'h7fffffff;
  localparam word_t TWIST_XOR  = 32'h9908b0df;
  localparam word_t SEED_MULT  = 32'd1812433253;
  localparam word_t SEED_RESET = 32'd4357;
  localparam logic [ZERO_W-1:0] ZERO_LIMIT = ZERO_W'(2 * N);
  localparam logic [IDX_W-1:0] FILL_LAST = IDX_W'(N - 1);

  typedef struct packed {
    logic shift;
    logic done;
  } fill_stat_t;

  function automatic word_t twist(input word_t w0, input word_t w1, input word_t wm);
    word_t y;
    y = (w0 & UPPER_BIT) | (w1 & LOWER_BITS);
    return wm ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
  endfunction

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MASK_B);
    y = y ^ ((y << 15) & MASK_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== design/mtzs_cell.sv =====
// One state word of the shift chain.
`timescale 1ns / 1ps
module mtzs_cell (
  input  logic          clk,
  input  logic          en,
  input  mtzs_pkg::word_t d,
  output mtzs_pkg::word_t q
);
  import mtzs_pkg::*;

  word_t word;

  always_ff @(posedge clk) begin
    if (en) begin
      word <= d;
    end
  end

  assign q = word;

endmodule

// ===== design/mtzs_chain.sv =====
// Row of state cells shifting towards the head, with the twist taps.
`timescale 1ns / 1ps
module mtzs_chain (
  input  logic            clk,
  input  logic            en,
  input  mtzs_pkg::word_t tail_in,
  output mtzs_pkg::word_t tap0,
  output mtzs_pkg::word_t tap1,
  output mtzs_pkg::word_t tapm
);
  import mtzs_pkg::*;

  word_t q [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    word_t d;
    if (i == N - 1) begin : g_tail
      assign d = tail_in;
    end else begin : g_body
      assign d = q[i + 1];
    end
    mtzs_cell u_cell (
      .clk (clk),
      .en  (en),
      .d   (d),
      .q   (q[i])
    );
  end

  assign tap0 = q[0];
  assign tap1 = q[1];
  assign tapm = q[M];

endmodule

// ===== design/mtzs_seeder.sv =====
// Seed recurrence that feeds the initial words into the chain.
`timescale 1ns / 1ps
module mtzs_seeder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mtzs_pkg::word_t      seed,
  output mtzs_pkg::word_t      word,
  output mtzs_pkg::fill_stat_t stat
);
  import mtzs_pkg::*;

  word_t            w;
  word_t            w_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             busy;

  assign idx_next = idx + IDX_W'(1);
  assign w_next   = (w ^ (w >> 30)) * SEED_MULT + {{(32 - IDX_W){1'b0}}, idx_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      idx  <= '0;
      w    <= SEED_RESET;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
      w    <= seed;
    end else if (busy) begin
      w   <= w_next;
      idx <= idx_next;
      if (idx == FILL_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  assign word       = w;
  assign stat.shift = busy;
  assign stat.done  = busy && (idx == FILL_LAST);

endmodule

// ===== design/mersenne_twister_zero_skip_top.sv =====
// Zero-skip twister generator top level. After reset and after every seed write the block
// loads the state chain, one word a cycle from the seed recurrence, and takes no request
// meanwhile. A request for n values (saturated to MAX_BATCH) then yields one tempered word
// per cycle while the result side does not stall, as each chain shift computes one new state
// word; zero words are skipped, and the run closes with the final word sent from FLUSH.
`timescale 1ns / 1ps
`include "mersenne_twister_zero_skip_top_defines.svh"
module mersenne_twister_zero_skip_top #(
  parameter int MAX_BATCH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [6:0]  count,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [31:0] value,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mtzs_pkg::*;

  localparam int REM_W = $clog2(MAX_BATCH + 1);
  localparam logic REG_SEED = 1'b0;

  typedef enum logic [3:0] {
    FILL  = 4'b0001,
    IDLE  = 4'b0010,
    RUN   = 4'b0100,
    FLUSH = 4'b1000
  } state_t;

  state_t            state;
  word_t             seed;
  word_t             hold;
  logic              hold_valid;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  cnt_sat;
  logic [ZERO_W-1:0] zeros;

  fill_stat_t fill;
  word_t      fill_word;
  word_t      tap0;
  word_t      tap1;
  word_t      tapm;
  word_t      new_word;
  word_t      tempered;
  logic       cfg_write;
  logic       out_free;
  logic       step;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SEED);
  assign prdata    = (paddr[2] == REG_SEED) ? seed : 32'd0;

  assign req_ready = (state == IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign step      = (state == RUN) && (!hold_valid || out_free);
  assign cnt_sat   = (count > 7'(MAX_BATCH)) ? REM_W'(MAX_BATCH) : REM_W'(count);

  assign new_word = twist(tap0, tap1, tapm);
  assign tempered = temper(new_word);

  mtzs_seeder u_seeder (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_write),
    .seed  (pwdata),
    .word  (fill_word),
    .stat  (fill)
  );

  mtzs_chain u_chain (
    .clk     (clk),
    .en      (fill.shift || step),
    .tail_in (fill.shift ? fill_word : new_word),
    .tap0    (tap0),
    .tap1    (tap1),
    .tapm    (tapm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FILL;
      seed       <= SEED_RESET;
      rsp_valid  <= 1'b0;
      hold_valid <= 1'b0;
      rem        <= '0;
      zeros      <= '0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_write) begin
        seed       <= pwdata;
        state      <= FILL;
        hold_valid <= 1'b0;
      end else begin
        unique case (state)
          FILL: begin
            if (fill.done) begin
              state <= IDLE;
            end
          end
          IDLE: begin
            if (req_valid && (cnt_sat != '0)) begin
              rem   <= cnt_sat;
              zeros <= '0;
              state <= RUN;
            end
          end
          RUN: begin
            if (step) begin
              if (tempered == 32'd0) begin
                if (zeros == ZERO_LIMIT) begin
                  state <= FLUSH;
                end else begin
                  zeros <= zeros + ZERO_W'(1);
                end
              end else begin
                zeros <= '0;
                if (hold_valid) begin
                  rsp_valid <= 1'b1;
                  value     <= hold;
                  last      <= 1'b0;
                end
                hold       <= tempered;
                hold_valid <= 1'b1;
                rem        <= rem - REM_W'(1);
                if (rem == REM_W'(1)) begin
                  state <= FLUSH;
                end
              end
            end
          end
          FLUSH: begin
            if (!hold_valid) begin
              state <= IDLE;
            end else if (out_free) begin
              rsp_valid  <= 1'b1;
              value      <= hold;
              last       <= 1'b1;
              hold_valid <= 1'b0;
              state      <= IDLE;
            end
          end
          default: begin
            state <= FILL;
          end
        endcase
      end
    end
  end

  `MTZS_ASSERT_IMP(a_idle_no_hold, req_ready, !hold_valid, "word held while idle")
  `MTZS_ASSERT_IMP(a_run_has_rem, state == RUN, rem != '0, "run with nothing left to make")
  `MTZS_ASSERT_IMP(a_zero_bound, 1'b1, zeros <= ZERO_LIMIT, "zero run counter overrun")
  `MTZS_ASSERT_NXT(a_fill_no_req, fill.shift && !fill.done, !req_ready,
                   "request taken during state load")

endmodule
